@@ src/three_level_feedback_scheduler_unit_defines.svh @@
// Assertion macros for the three-level feedback scheduler.
`ifndef THREE_LEVEL_FEEDBACK_SCHEDULER_UNIT_DEFINES_SVH
`define THREE_LEVEL_FEEDBACK_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TLFS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// next-cycle implication, checked outside reset
`define TLFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

@@ src/tlfs_pkg.sv @@
// Package: constants, codes and sequencer states of the feedback scheduler.
`default_nettype none
package tlfs_pkg;
    localparam int MAX_JOBS  = 16;
    localparam int ID_W      = $clog2(MAX_JOBS);
    localparam int CNT_W     = $clog2(MAX_JOBS + 1);
    localparam int JOB_ID_W  = 4;
    localparam int TIME_W    = 32;
    localparam int OUT_W     = 32;
    localparam int BURST_W   = 16;
    localparam int QUANT_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_QUANTUM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_QUANTUM = 2'd1;
    localparam logic [QUANT_W-1:0]   FIRST_QUANTUM_RST  = 16'd4;
    localparam logic [QUANT_W-1:0]   SECOND_QUANTUM_RST = 16'd8;

    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TOP,
        ST_TOP_SERVE,
        ST_MID,
        ST_INS_KEY,
        ST_INS_SCAN,
        ST_MID_SERVE,
        ST_BOT,
        ST_TURN,
        ST_OUT
    } tlfs_state_t;
endpackage
`default_nettype wire

@@ src/three_level_feedback_scheduler_unit.sv @@
// Three-level feedback scheduler: sequencer, job tables, queues and result register.
//
//   channel | direction | handshake            | payload
//   s_      | in        | s_valid / s_ready    | s_cmd, s_job_id, s_job_burst
//   m_      | out       | m_valid / m_ready    | m_done_res, m_done_job, m_wait_time,
//           |           |                      | m_turnaround_time, m_all_idle
//   cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An arrive transaction is taken in ST_IDLE; a tick walks ST_TOP, ST_TOP_SERVE,
// ST_MID, ST_MID_SERVE, ST_BOT, ST_TURN and ST_OUT, plus ST_INS_KEY and ST_INS_SCAN
// when a middle job drops to the bottom list (the single compare unit steps over up
// to 15 entries) and stalls in ST_OUT on m_ready. The remaining-burst port is shared.
// Reset is synchronous; no clearing pass is needed. cfg_ready is always high.
`default_nettype none
module three_level_feedback_scheduler_unit
    import tlfs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_cmd,
    input  wire logic [JOB_ID_W-1:0]  s_job_id,
    input  wire logic [BURST_W-1:0]   s_job_burst,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_done_res,
    output logic [JOB_ID_W-1:0]       m_done_job,
    output logic [OUT_W-1:0]          m_wait_time,
    output logic [OUT_W-1:0]          m_turnaround_time,
    output logic                      m_all_idle,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [QUANT_W-1:0]   cfg_data
);
`include "three_level_feedback_scheduler_unit_defines.svh"

    tlfs_state_t state_reg, state_next;

    logic [TIME_W-1:0]  now_reg;
    logic [TIME_W-1:0]  arr_reg [MAX_JOBS];
    logic [BURST_W-1:0] fb_reg  [MAX_JOBS];
    logic [BURST_W-1:0] rem_reg [MAX_JOBS];
    logic [MAX_JOBS-1:0] busy_reg;

    logic [ID_W-1:0]  top_q_reg [MAX_JOBS];
    logic [ID_W-1:0]  mid_q_reg [MAX_JOBS];
    logic [ID_W-1:0]  bot_q_reg [MAX_JOBS];
    logic [ID_W-1:0]  top_head_reg, mid_head_reg;
    logic [CNT_W-1:0] top_cnt_reg, mid_cnt_reg, bot_cnt_reg;

    logic [QUANT_W-1:0] fq_reg, sq_reg, top_slice_reg, mid_slice_reg;

    logic               served_reg, fin_reg;
    logic [ID_W-1:0]    fin_id_reg, ins_id_reg;
    logic [BURST_W-1:0] key_reg;
    logic [CNT_W-1:0]   pos_reg;
    logic [TIME_W-1:0]  turn_reg;

    logic                m_valid_reg, m_done_reg, m_idle_reg;
    logic [JOB_ID_W-1:0] m_job_reg;
    logic [OUT_W-1:0]    m_wait_reg, m_turn_reg;

    logic [ID_W-1:0]    rem_addr;
    logic [BURST_W-1:0] rem_rd, rem_dec, rem_val;
    logic [ID_W-1:0]    top_id, mid_id, bot_id, slot;
    logic               arrive_ok, scan_more, out_free, top_any, mid_any, bot_any;
    logic [TIME_W-1:0]  wait_full;

    assign top_id   = top_q_reg[top_head_reg];
    assign mid_id   = mid_q_reg[mid_head_reg];
    assign bot_id   = bot_q_reg[0];
    assign slot     = ID_W'(s_job_id);
    assign rem_rd   = rem_reg[rem_addr];
    assign rem_dec  = rem_rd - 1'b1;
    assign rem_val  = served_reg ? rem_rd : rem_dec;
    assign top_any  = (top_cnt_reg != '0);
    assign mid_any  = (mid_cnt_reg != '0);
    assign bot_any  = (bot_cnt_reg != '0);
    assign out_free = !m_valid_reg || m_ready;
    assign scan_more = (pos_reg < bot_cnt_reg) && (rem_rd <= key_reg);
    assign arrive_ok = (32'(s_job_id) < MAX_JOBS) && (s_job_burst != '0) &&
                       !busy_reg[slot] && (32'(top_cnt_reg) < MAX_JOBS);
    assign wait_full = turn_reg - TIME_W'(fb_reg[fin_id_reg]);

    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        cfg_ready = 1'b1;
        case (state_reg)
            ST_TOP_SERVE: rem_addr = top_id;
            ST_INS_KEY:   rem_addr = ins_id_reg;
            ST_INS_SCAN:  rem_addr = bot_q_reg[pos_reg[ID_W-1:0]];
            ST_MID_SERVE: rem_addr = mid_id;
            ST_BOT:       rem_addr = bot_id;
            default:      rem_addr = slot;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_valid && s_cmd == CMD_TICK) state_next = ST_TOP;
            ST_TOP:       state_next = ST_TOP_SERVE;
            ST_TOP_SERVE: state_next = ST_MID;
            ST_MID: begin
                if (!top_any && mid_any && mid_slice_reg == '0) state_next = ST_INS_KEY;
                else state_next = ST_MID_SERVE;
            end
            ST_INS_KEY:   state_next = ST_INS_SCAN;
            ST_INS_SCAN:  if (!scan_more) state_next = ST_MID_SERVE;
            ST_MID_SERVE: state_next = ST_BOT;
            ST_BOT:       state_next = ST_TURN;
            ST_TURN:      state_next = ST_OUT;
            ST_OUT:       if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            busy_reg      <= '0;
            top_head_reg  <= '0;
            mid_head_reg  <= '0;
            top_cnt_reg   <= '0;
            mid_cnt_reg   <= '0;
            bot_cnt_reg   <= '0;
            fq_reg        <= FIRST_QUANTUM_RST;
            sq_reg        <= SECOND_QUANTUM_RST;
            top_slice_reg <= FIRST_QUANTUM_RST;
            mid_slice_reg <= SECOND_QUANTUM_RST;
            served_reg    <= 1'b0;
            fin_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_FIRST_QUANTUM:  fq_reg <= cfg_data;
                    CFG_SECOND_QUANTUM: sq_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    served_reg <= 1'b0;
                    fin_reg    <= 1'b0;
                    if (s_valid && s_cmd == CMD_ARRIVE && arrive_ok) begin
                        busy_reg[slot] <= 1'b1;
                        arr_reg[slot]  <= now_reg;
                        fb_reg[slot]   <= s_job_burst;
                        rem_reg[slot]  <= s_job_burst;
                        top_q_reg[top_head_reg + top_cnt_reg[ID_W-1:0]] <= slot;
                        top_cnt_reg    <= top_cnt_reg + 1'b1;
                    end
                end
                ST_TOP: begin
                    if (top_any && top_slice_reg == '0) begin
                        top_slice_reg <= fq_reg;
                        top_head_reg  <= top_head_reg + 1'b1;
                        top_cnt_reg   <= top_cnt_reg - 1'b1;
                        if (32'(mid_cnt_reg) < MAX_JOBS) begin
                            mid_q_reg[mid_head_reg + mid_cnt_reg[ID_W-1:0]] <= top_id;
                            mid_cnt_reg <= mid_cnt_reg + 1'b1;
                        end
                    end
                end
                ST_TOP_SERVE: begin
                    if (top_any) begin
                        rem_reg[top_id] <= rem_dec;
                        served_reg      <= 1'b1;
                        top_slice_reg   <= top_slice_reg - 1'b1;
                        if (rem_dec == '0) begin
                            top_slice_reg    <= fq_reg;
                            fin_reg          <= 1'b1;
                            fin_id_reg       <= top_id;
                            busy_reg[top_id] <= 1'b0;
                            top_head_reg     <= top_head_reg + 1'b1;
                            top_cnt_reg      <= top_cnt_reg - 1'b1;
                        end
                    end
                end
                ST_MID: begin
                    if (!top_any && mid_any && mid_slice_reg == '0) begin
                        mid_slice_reg <= sq_reg;
                        ins_id_reg    <= mid_id;
                        mid_head_reg  <= mid_head_reg + 1'b1;
                        mid_cnt_reg   <= mid_cnt_reg - 1'b1;
                    end
                end
                ST_INS_KEY: begin
                    key_reg <= rem_rd;
                    pos_reg <= '0;
                end
                ST_INS_SCAN: begin
                    if (scan_more) begin
                        pos_reg <= pos_reg + 1'b1;
                    end else if (32'(bot_cnt_reg) < MAX_JOBS) begin
                        for (int i = 1; i < MAX_JOBS; i++) begin
                            if (CNT_W'(i) > pos_reg) bot_q_reg[i] <= bot_q_reg[i-1];
                        end
                        bot_q_reg[pos_reg[ID_W-1:0]] <= ins_id_reg;
                        bot_cnt_reg <= bot_cnt_reg + 1'b1;
                    end
                end
                ST_MID_SERVE: begin
                    if (!top_any && mid_any) begin
                        if (!served_reg) begin
                            rem_reg[mid_id] <= rem_dec;
                            mid_slice_reg   <= mid_slice_reg - 1'b1;
                            served_reg      <= 1'b1;
                        end
                        if (rem_val == '0) begin
                            mid_slice_reg    <= sq_reg;
                            fin_reg          <= 1'b1;
                            fin_id_reg       <= mid_id;
                            busy_reg[mid_id] <= 1'b0;
                            mid_head_reg     <= mid_head_reg + 1'b1;
                            mid_cnt_reg      <= mid_cnt_reg - 1'b1;
                        end
                    end
                end
                ST_BOT: begin
                    if (!top_any && !mid_any && bot_any) begin
                        if (!served_reg) rem_reg[bot_id] <= rem_dec;
                        if (rem_val == '0) begin
                            fin_reg          <= 1'b1;
                            fin_id_reg       <= bot_id;
                            busy_reg[bot_id] <= 1'b0;
                            for (int i = 0; i < MAX_JOBS - 1; i++) begin
                                bot_q_reg[i] <= bot_q_reg[i+1];
                            end
                            bot_cnt_reg <= bot_cnt_reg - 1'b1;
                        end
                    end
                end
                ST_TURN: begin
                    turn_reg <= now_reg + 1'b1 - arr_reg[fin_id_reg];
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_done_reg  <= fin_reg;
                        m_job_reg   <= fin_reg ? JOB_ID_W'(fin_id_reg) : '0;
                        m_wait_reg  <= fin_reg ? OUT_W'(wait_full) : '0;
                        m_turn_reg  <= fin_reg ? OUT_W'(turn_reg) : '0;
                        m_idle_reg  <= !top_any && !mid_any && !bot_any;
                        now_reg     <= now_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_done_res        = m_done_reg;
    assign m_done_job        = m_job_reg;
    assign m_wait_time       = m_wait_reg;
    assign m_turnaround_time = m_turn_reg;
    assign m_all_idle        = m_idle_reg;

    `TLFS_ASSERT_NOW(a_busy_matches_queues, state_reg == ST_IDLE,
        $countones(busy_reg) == 32'(top_cnt_reg) + 32'(mid_cnt_reg) + 32'(bot_cnt_reg))
    `TLFS_ASSERT_NOW(a_no_done_zero_fields, m_valid_reg && !m_done_reg,
        m_job_reg == '0 && m_wait_reg == '0 && m_turn_reg == '0)
    `TLFS_ASSERT_NEXT(a_time_advances, state_reg == ST_OUT && out_free,
        now_reg == $past(now_reg) + 1'b1 && m_valid_reg)

endmodule
`default_nettype wire
